FILE: rtl/core/cfpc_pkg.sv
// shared types, codes and character constants for the colon frame parity checker
package cfpc_pkg;

  localparam int FRAME_BYTES_DEF = 128;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [2:0] FLD_ID  = 3'd0;
  localparam logic [2:0] FLD_LEN = 3'd1;
  localparam logic [2:0] FLD_MSG = 3'd2;
  localparam logic [2:0] FLD_PAR = 3'd3;
  localparam logic [2:0] FLD_MAX = 3'd7;

  localparam logic [6:0] MSG_MAX = 7'd127;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  typedef struct packed {
    logic       frame_ok;
    logic [7:0] frame_id;
    logic [7:0] declared_len;
    logic [6:0] message_len;
    logic [7:0] received_parity;
    logic [7:0] computed_parity;
  } result_t;

  function automatic logic [7:0] signed_value(input logic neg, input logic [7:0] val);
    signed_value = neg ? 8'(8'd0 - val) : val;
  endfunction

endpackage

FILE: rtl/core/colon_frame_parity_checker_top.sv
// colon frame parity checker: byte-wise frame parser with a two-slot result buffer
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------------
//   in      | in_valid / in_ready  | data_byte, end_of_frame
//   out     | out_valid / out_ready| frame_ok, frame_id, declared_len, message_len,
//           |                      | received_parity, computed_parity
//
// one byte per cycle while in_ready is high; parser state is updated in the cycle
// of the request, and the request carrying end_of_frame also registers its result
// one skid slot behind the result register takes a result while out is stalled
// in_ready is low only while both result slots are full
// rst is synchronous and clears the parser and both slots
module colon_frame_parity_checker_top #(
  parameter int FRAME_BYTES = cfpc_pkg::FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       frame_ok,
  output logic [7:0] frame_id,
  output logic [7:0] declared_len,
  output logic [6:0] message_len,
  output logic [7:0] received_parity,
  output logic [7:0] computed_parity
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);

  logic [2:0]       field_number, field_number_next;
  cfpc_pkg::phase_t number_phase, number_phase_next;
  logic             number_negative, number_negative_next;
  logic [7:0]       number_value, number_value_next;
  logic [7:0]       id_value, id_value_next;
  logic [7:0]       length_value, length_value_next;
  logic [7:0]       parity_value, parity_value_next;
  logic [7:0]       message_xor, message_xor_next;
  logic [6:0]       message_count, message_count_next;
  logic             string_done, string_done_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;

  cfpc_pkg::result_t res_next, res_main, res_skid;
  logic              skid_valid;
  logic              accept, push, pop;

  assign accept = in_valid && in_ready;
  assign push   = accept && end_of_frame;
  assign pop    = out_valid && out_ready;

  always_comb begin
    logic       is_space;
    logic       is_digit;
    logic       commit;
    logic       bump;
    logic [7:0] v;
    logic [7:0] comp;

    field_number_next    = field_number;
    number_phase_next    = number_phase;
    number_negative_next = number_negative;
    number_value_next    = number_value;
    id_value_next        = id_value;
    length_value_next    = length_value;
    parity_value_next    = parity_value;
    message_xor_next     = message_xor;
    message_count_next   = message_count;
    string_done_next     = string_done;
    byte_count_next      = byte_count;

    is_space = data_byte inside {cfpc_pkg::CH_SPACE, [cfpc_pkg::CH_TAB:cfpc_pkg::CH_CR]};
    is_digit = data_byte inside {[cfpc_pkg::CH_ZERO:cfpc_pkg::CH_NINE]};
    commit   = 1'b0;
    bump     = 1'b0;
    v        = 8'd0;

    // parse the byte
    if (!string_done) begin
      if (data_byte == cfpc_pkg::CH_NUL) begin
        commit           = 1'b1;
        string_done_next = 1'b1;
      end else if (data_byte == cfpc_pkg::CH_COLON) begin
        commit = 1'b1;
        bump   = 1'b1;
      end else if (field_number == cfpc_pkg::FLD_MSG) begin
        message_xor_next = message_xor ^ data_byte;
        if (message_count != cfpc_pkg::MSG_MAX) begin
          message_count_next = message_count + 7'd1;
        end
      end else if (field_number inside {cfpc_pkg::FLD_ID, cfpc_pkg::FLD_LEN,
                                        cfpc_pkg::FLD_PAR}) begin
        case (number_phase)
          cfpc_pkg::PH_SKIP: begin
            if (data_byte == cfpc_pkg::CH_PLUS || data_byte == cfpc_pkg::CH_MINUS) begin
              number_negative_next = (data_byte == cfpc_pkg::CH_MINUS);
              number_phase_next    = cfpc_pkg::PH_NUM;
            end else if (!is_space) begin
              if (is_digit) begin
                number_phase_next = cfpc_pkg::PH_NUM;
                number_value_next = (number_value << 3) + (number_value << 1) +
                                    (data_byte - cfpc_pkg::CH_ZERO);
              end else begin
                number_phase_next = cfpc_pkg::PH_STOP;
              end
            end
          end
          cfpc_pkg::PH_NUM: begin
            if (is_digit) begin
              number_value_next = (number_value << 3) + (number_value << 1) +
                                  (data_byte - cfpc_pkg::CH_ZERO);
            end else begin
              number_phase_next = cfpc_pkg::PH_STOP;
            end
          end
          default: begin
          end
        endcase
      end
      byte_count_next = byte_count + CNT_W'(1);
    end

    // field commit on a separator or the end of the string
    if (commit) begin
      v = cfpc_pkg::signed_value(number_negative, number_value);
      case (field_number)
        cfpc_pkg::FLD_ID:  id_value_next     = v;
        cfpc_pkg::FLD_LEN: length_value_next = v;
        cfpc_pkg::FLD_PAR: parity_value_next = v;
        default: begin
        end
      endcase
      number_phase_next    = cfpc_pkg::PH_SKIP;
      number_negative_next = 1'b0;
      number_value_next    = 8'd0;
    end
    if (bump && field_number != cfpc_pkg::FLD_MAX) begin
      field_number_next = field_number + 3'd1;
    end

    // end of string by byte limit or by end of frame
    if (!string_done_next &&
        (byte_count_next == CNT_W'(FRAME_BYTES) || end_of_frame)) begin
      v = cfpc_pkg::signed_value(number_negative_next, number_value_next);
      case (field_number_next)
        cfpc_pkg::FLD_ID:  id_value_next     = v;
        cfpc_pkg::FLD_LEN: length_value_next = v;
        cfpc_pkg::FLD_PAR: parity_value_next = v;
        default: begin
        end
      endcase
      number_phase_next    = cfpc_pkg::PH_SKIP;
      number_negative_next = 1'b0;
      number_value_next    = 8'd0;
      string_done_next     = 1'b1;
    end

    comp = id_value_next ^ length_value_next ^ message_xor_next;
    res_next.frame_ok        = (parity_value_next == comp) && (message_count_next != 7'd0);
    res_next.frame_id        = id_value_next;
    res_next.declared_len    = length_value_next;
    res_next.message_len     = message_count_next;
    res_next.received_parity = parity_value_next;
    res_next.computed_parity = comp;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst || push) begin
      field_number    <= cfpc_pkg::FLD_ID;
      number_phase    <= cfpc_pkg::PH_SKIP;
      number_negative <= 1'b0;
      number_value    <= 8'd0;
      id_value        <= 8'd0;
      length_value    <= 8'd0;
      parity_value    <= 8'd0;
      message_xor     <= 8'd0;
      message_count   <= 7'd0;
      string_done     <= 1'b0;
      byte_count      <= '0;
    end else if (accept) begin
      field_number    <= field_number_next;
      number_phase    <= number_phase_next;
      number_negative <= number_negative_next;
      number_value    <= number_value_next;
      id_value        <= id_value_next;
      length_value    <= length_value_next;
      parity_value    <= parity_value_next;
      message_xor     <= message_xor_next;
      message_count   <= message_count_next;
      string_done     <= string_done_next;
      byte_count      <= byte_count_next;
    end
  end

  // result register and skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        res_main <= res_skid;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        res_main <= res_next;
      end else begin
        res_skid <= res_next;
      end
    end
  end

  assign in_ready        = !skid_valid;
  assign frame_ok        = res_main.frame_ok;
  assign frame_id        = res_main.frame_id;
  assign declared_len    = res_main.declared_len;
  assign message_len     = res_main.message_len;
  assign received_parity = res_main.received_parity;
  assign computed_parity = res_main.computed_parity;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while result register empty");

  a_result_follows_eof: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("no result after end of frame request");

  a_clear_after_eof: assert property (@(posedge clk) disable iff (rst)
    push |=> (field_number == cfpc_pkg::FLD_ID) && !string_done && (byte_count == '0))
    else $error("parser not cleared after end of frame");

  a_ok_needs_message: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_ok) |-> (message_len != 7'd0) &&
                                (received_parity == computed_parity))
    else $error("frame_ok set without message or parity match");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (byte_count <= CNT_W'(FRAME_BYTES)) && (string_done || byte_count < CNT_W'(FRAME_BYTES)))
    else $error("byte count beyond frame limit");

endmodule
